[design/tea_pkg.sv]
// Shared types and constants for the touch event assembler and calibrator.
// Used by tea_ctrl, tea_dp, the top level and the port checker; depends on nothing.
package tea_pkg;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF      = 16;
    localparam int SCALE_FRAC_BITS_DEF = 12;

    // Stream payload widths.
    localparam int TYPE_W    = 5;
    localparam int CODE_W    = 10;
    localparam int VALUE_W   = 32;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 88;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_XY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_X_GAINS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_Y_GAINS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSETS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_DIVISOR   = 3'd7;

    localparam logic [31:0] SCALE_XY_RESET      = 32'h1000_1000;
    localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;

    // Event codes.
    localparam logic [TYPE_W-1:0] EV_SYNC_TYPE = 5'd0;
    localparam logic [TYPE_W-1:0] EV_ABS_TYPE  = 5'd3;
    localparam logic [CODE_W-1:0] CODE_POS_X   = 10'h035;
    localparam logic [CODE_W-1:0] CODE_POS_Y   = 10'h036;
    localparam logic [CODE_W-1:0] CODE_MAJOR   = 10'h030;

    // Shared multiplier: 33 x 17 signed operands, 50-bit product.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int ACC_W   = MUL_A_W + MUL_B_W;
    localparam int DEN_W   = 32;

    typedef enum logic [2:0] {
        EVK_NONE,
        EVK_POS_X,
        EVK_POS_Y,
        EVK_MAJOR,
        EVK_SYNC
    } ev_kind_t;

    typedef enum logic [2:0] {
        MUL_SCALE,
        MUL_GXX,
        MUL_GXY,
        MUL_GYX,
        MUL_GYY
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     store_coord;
        logic     store_size;
        logic     acc_init;
        mul_sel_t mul_sel;
        logic     acc_x_en;
        logic     acc_y_en;
        logic     div_start;
        logic     out_load;
    } tea_cmd_t;

    typedef struct packed {
        ev_kind_t kind;
        logic     use_cal;
        logic     div_busy;
    } tea_status_t;

endpackage

[design/tea_div.sv]
// Restoring serial divider on unsigned magnitudes, one quotient bit per cycle.
// Depends on nothing; instantiated by tea_dp.
module tea_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

[design/tea_ctrl.sv]
// Sequencer of the touch event assembler: decodes events, steps the
// calibration and owns the pending flag and result valid. Depends on tea_pkg.
module tea_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  tea_pkg::tea_status_t status,
    output tea_pkg::tea_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DECODE    = 7'b0000010,
        ST_SCALE     = 7'b0000100,
        ST_CAL_MUL   = 7'b0001000,
        ST_DIV_START = 7'b0010000,
        ST_DIV_WAIT  = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       pending_reg, pending_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        pending_next = pending_reg;
        cmd          = '0;
        cmd.mul_sel  = tea_pkg::MUL_SCALE;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.acc_init = 1'b1;
                unique case (status.kind)
                    tea_pkg::EVK_POS_X, tea_pkg::EVK_POS_Y:
                    begin
                        state_next = ST_SCALE;
                    end
                    tea_pkg::EVK_MAJOR:
                    begin
                        cmd.store_size = 1'b1;
                        pending_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    tea_pkg::EVK_SYNC:
                    begin
                        pending_next = 1'b0;
                        if (!pending_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (status.use_cal)
                        begin
                            step_next  = '0;
                            state_next = ST_CAL_MUL;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCALE:
            begin
                cmd.store_coord = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_CAL_MUL:
            begin
                // A product is issued in one step and added in the next.
                unique case (step_reg)
                    3'd0:    cmd.mul_sel = tea_pkg::MUL_GXX;
                    3'd1:    cmd.mul_sel = tea_pkg::MUL_GXY;
                    3'd2:    cmd.mul_sel = tea_pkg::MUL_GYX;
                    3'd3:    cmd.mul_sel = tea_pkg::MUL_GYY;
                    default: cmd.mul_sel = tea_pkg::MUL_SCALE;
                endcase
                cmd.acc_x_en = (step_reg == 3'd1) || (step_reg == 3'd2);
                cmd.acc_y_en = (step_reg == 3'd3) || (step_reg == 3'd4);
                step_next    = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

[design/tea_dp.sv]
// Datapath of the touch event assembler: configuration registers, touch state,
// shared multiplier, two serial dividers and the result register.
// Depends on tea_pkg and tea_div.
module tea_dp #(
    parameter int COORD_BITS      = tea_pkg::COORD_BITS_DEF,
    parameter int SCALE_FRAC_BITS = tea_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr,
    input  logic [tea_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tea_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [tea_pkg::TYPE_W-1:0]      in_type,
    input  logic [tea_pkg::S_TDATA_W-1:0]   in_data,
    input  tea_pkg::tea_cmd_t               cmd,
    output tea_pkg::tea_status_t            status,
    output logic [tea_pkg::M_TDATA_W-1:0]   out_data
);

    localparam int ACC_W  = tea_pkg::ACC_W;
    localparam int DEN_W  = tea_pkg::DEN_W;
    localparam int PROD_W = 48;

    // Configuration.
    logic        panel_mode_reg;
    logic [31:0] scale_xy_reg;
    logic [7:0]  edge_margin_reg;
    logic [11:0] screen_height_reg;
    logic [63:0] cal_x_gains_reg;
    logic [63:0] cal_y_gains_reg;
    logic [63:0] cal_offsets_reg;
    logic [31:0] cal_divisor_reg;

    // Captured event.
    logic [tea_pkg::TYPE_W-1:0]  ev_type_reg;
    logic [tea_pkg::CODE_W-1:0]  ev_code_reg;
    logic signed [31:0]          ev_value_reg;

    // Touch state.
    logic signed [COORD_BITS-1:0] cur_x_reg;
    logic signed [COORD_BITS-1:0] cur_y_reg;
    logic [15:0]                  cur_size_reg;
    logic [15:0]                  last_size_reg;

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_x_reg;
    logic signed [ACC_W-1:0] acc_y_reg;
    logic [tea_pkg::M_TDATA_W-1:0] out_data_reg;

    logic div_x_busy;
    logic div_y_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_mode_reg    <= 1'b0;
            scale_xy_reg      <= tea_pkg::SCALE_XY_RESET;
            edge_margin_reg   <= '0;
            screen_height_reg <= tea_pkg::SCREEN_HEIGHT_RESET;
            cal_x_gains_reg   <= '0;
            cal_y_gains_reg   <= '0;
            cal_offsets_reg   <= '0;
            cal_divisor_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                tea_pkg::CFG_PANEL_MODE:    panel_mode_reg    <= cfg_data[0];
                tea_pkg::CFG_SCALE_XY:      scale_xy_reg      <= cfg_data[31:0];
                tea_pkg::CFG_EDGE_MARGIN:   edge_margin_reg   <= cfg_data[7:0];
                tea_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[11:0];
                tea_pkg::CFG_CAL_X_GAINS:   cal_x_gains_reg   <= cfg_data;
                tea_pkg::CFG_CAL_Y_GAINS:   cal_y_gains_reg   <= cfg_data;
                tea_pkg::CFG_CAL_OFFSETS:   cal_offsets_reg   <= cfg_data;
                tea_pkg::CFG_CAL_DIVISOR:   cal_divisor_reg   <= cfg_data[31:0];
                default:                    panel_mode_reg    <= panel_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ev_type_reg  <= in_type;
            ev_code_reg  <= in_data[tea_pkg::CODE_W-1:0];
            ev_value_reg <= in_data[tea_pkg::CODE_W +: tea_pkg::VALUE_W];
        end
    end

    always_comb
    begin
        status = '0;
        if (ev_type_reg == tea_pkg::EV_ABS_TYPE)
        begin
            priority if (ev_code_reg == tea_pkg::CODE_POS_X)
                status.kind = tea_pkg::EVK_POS_X;
            else if (ev_code_reg == tea_pkg::CODE_POS_Y)
                status.kind = tea_pkg::EVK_POS_Y;
            else if (ev_code_reg == tea_pkg::CODE_MAJOR)
                status.kind = tea_pkg::EVK_MAJOR;
            else
                status.kind = tea_pkg::EVK_NONE;
        end
        else if (ev_type_reg == tea_pkg::EV_SYNC_TYPE)
        begin
            status.kind = tea_pkg::EVK_SYNC;
        end
        else
        begin
            status.kind = tea_pkg::EVK_NONE;
        end
        status.use_cal  = panel_mode_reg && (cal_divisor_reg != '0);
        status.div_busy = div_x_busy || div_y_busy;
    end

    // Shared signed multiplier. Scaling uses it on magnitudes with a zero sign bit.
    logic [31:0]                     value_mag;
    logic [15:0]                     scale_factor;
    logic signed [tea_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tea_pkg::MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]         mul_p;

    assign value_mag    = ev_value_reg[31] ? 32'(-ev_value_reg) : ev_value_reg;
    assign scale_factor = (ev_code_reg == tea_pkg::CODE_POS_X) ? scale_xy_reg[15:0]
                                                               : scale_xy_reg[31:16];

    always_comb
    begin
        unique case (cmd.mul_sel)
            tea_pkg::MUL_GXX:
            begin
                mul_a = tea_pkg::MUL_A_W'($signed(cal_x_gains_reg[31:0]));
                mul_b = tea_pkg::MUL_B_W'(cur_x_reg);
            end
            tea_pkg::MUL_GXY:
            begin
                mul_a = tea_pkg::MUL_A_W'($signed(cal_x_gains_reg[63:32]));
                mul_b = tea_pkg::MUL_B_W'(cur_y_reg);
            end
            tea_pkg::MUL_GYX:
            begin
                mul_a = tea_pkg::MUL_A_W'($signed(cal_y_gains_reg[31:0]));
                mul_b = tea_pkg::MUL_B_W'(cur_x_reg);
            end
            tea_pkg::MUL_GYY:
            begin
                mul_a = tea_pkg::MUL_A_W'($signed(cal_y_gains_reg[63:32]));
                mul_b = tea_pkg::MUL_B_W'(cur_y_reg);
            end
            default:
            begin
                mul_a = $signed({1'b0, value_mag});
                mul_b = $signed({1'b0, scale_factor});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (cmd.acc_init)
        begin
            acc_x_reg <= ACC_W'($signed(cal_offsets_reg[31:0]));
            acc_y_reg <= ACC_W'($signed(cal_offsets_reg[63:32]));
        end
        else
        begin
            if (cmd.acc_x_en)
            begin
                acc_x_reg <= acc_x_reg + prod_reg;
            end
            if (cmd.acc_y_en)
            begin
                acc_y_reg <= acc_y_reg + prod_reg;
            end
        end
    end

    // Scaled coordinate: truncate the magnitude, then saturate to COORD_BITS.
    localparam logic [PROD_W-1:0] COORD_LIM = PROD_W'(1) << (COORD_BITS - 1);
    localparam logic [COORD_BITS-1:0] COORD_MIN = COORD_BITS'(1) << (COORD_BITS - 1);
    localparam logic [COORD_BITS-1:0] COORD_MAX = ~COORD_MIN;

    logic [PROD_W-1:0]     scaled_mag;
    logic [COORD_BITS-1:0] scaled_coord;

    assign scaled_mag = prod_reg[PROD_W-1:0] >> SCALE_FRAC_BITS;

    always_comb
    begin
        if (ev_value_reg[31])
        begin
            scaled_coord = (scaled_mag >= COORD_LIM) ? COORD_MIN
                                                     : COORD_BITS'(-scaled_mag);
        end
        else
        begin
            scaled_coord = (scaled_mag >= COORD_LIM) ? COORD_MAX
                                                     : scaled_mag[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_size_reg  <= '0;
            last_size_reg <= '0;
        end
        else
        begin
            if (cmd.store_coord)
            begin
                if (ev_code_reg == tea_pkg::CODE_POS_X)
                begin
                    cur_x_reg <= scaled_coord;
                end
                else
                begin
                    cur_y_reg <= scaled_coord;
                end
            end
            if (cmd.store_size)
            begin
                if (ev_value_reg[31])
                    cur_size_reg <= '0;
                else if (ev_value_reg[30:16] != '0)
                    cur_size_reg <= 16'hFFFF;
                else
                    cur_size_reg <= ev_value_reg[15:0];
            end
            if (cmd.out_load)
            begin
                last_size_reg <= cur_size_reg;
            end
        end
    end

    // Division on magnitudes; the sign is put back afterwards, which truncates toward zero.
    logic [ACC_W-1:0] num_x_mag;
    logic [ACC_W-1:0] num_y_mag;
    logic [DEN_W-1:0] den_mag;
    logic [ACC_W-1:0] quo_x_mag;
    logic [ACC_W-1:0] quo_y_mag;

    assign num_x_mag = acc_x_reg[ACC_W-1] ? ACC_W'(-acc_x_reg) : acc_x_reg;
    assign num_y_mag = acc_y_reg[ACC_W-1] ? ACC_W'(-acc_y_reg) : acc_y_reg;
    assign den_mag   = cal_divisor_reg[31] ? DEN_W'(-cal_divisor_reg) : cal_divisor_reg;

    tea_div #(
        .NUM_W (ACC_W),
        .DEN_W (DEN_W)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_x_mag),
        .den   (den_mag),
        .busy  (div_x_busy),
        .quo   (quo_x_mag)
    );

    tea_div #(
        .NUM_W (ACC_W),
        .DEN_W (DEN_W)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_y_mag),
        .den   (den_mag),
        .busy  (div_y_busy),
        .quo   (quo_y_mag)
    );

    function automatic logic [15:0] sat_quo(input logic [ACC_W-1:0] mag, input logic neg);
        logic [15:0] res;
        if (neg)
            res = (mag > ACC_W'(32768)) ? 16'h8000 : 16'(-mag);
        else
            res = (mag > ACC_W'(32767)) ? 16'h7FFF : mag[15:0];
        return res;
    endfunction

    function automatic logic [15:0] sat18(input logic signed [17:0] v);
        logic [15:0] res;
        if (v > 18'sd32767)
            res = 16'h7FFF;
        else if (v < -18'sd32768)
            res = 16'h8000;
        else
            res = v[15:0];
        return res;
    endfunction

    // Result assembly.
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [17:0] py18;
    logic signed [17:0] m18;
    logic signed [17:0] h18;
    logic signed [17:0] nudged_y;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic               cal_error;
    logic               contact_changed;

    assign raw_x = 16'(cur_x_reg);
    assign raw_y = 16'(cur_y_reg);
    assign py18  = 18'(cur_y_reg);
    assign m18   = $signed({10'd0, edge_margin_reg});
    assign h18   = $signed({6'd0, screen_height_reg});

    always_comb
    begin
        priority if (py18 + m18 > h18)
            nudged_y = py18 - m18;
        else if (py18 < m18)
            nudged_y = py18 + m18;
        else
            nudged_y = py18;
    end

    always_comb
    begin
        cal_error = 1'b0;
        if (!panel_mode_reg)
        begin
            pos_x = raw_x;
            pos_y = sat18(nudged_y);
        end
        else if (cal_divisor_reg == '0)
        begin
            pos_x     = raw_x;
            pos_y     = raw_y;
            cal_error = 1'b1;
        end
        else
        begin
            pos_x = sat_quo(quo_x_mag, acc_x_reg[ACC_W-1] ^ cal_divisor_reg[31]);
            pos_y = sat_quo(quo_y_mag, acc_y_reg[ACC_W-1] ^ cal_divisor_reg[31]);
        end
    end

    assign contact_changed = (cur_size_reg != last_size_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {6'd0, cal_error, contact_changed, cur_size_reg,
                             pos_y, pos_x, raw_y, raw_x};
        end
    end

    assign out_data = out_data_reg;

endmodule

[design/touch_event_assembler_calibrator.sv]
// Touch event assembler and calibrator, top level.
// Depends on tea_pkg, tea_ctrl, tea_dp (and through it tea_div).
//
// Input events arrive on the s_ stream, one request per event: s_tuser carries
// the event type, s_tdata the code and the signed value. Absolute X and Y events
// are scaled and stored, a touch-major event stores the contact size and arms a
// report, and a sync event with an armed report produces one request on the m_
// stream. All other events are absorbed without a result.
// Configuration goes through the cfg_ write channel, one register per request;
// it is always ready and must only be used while no event is in flight.
// A position event is decoded, then scaled and stored; a size event is stored
// at decode. A sync report in capacitive mode, or with a zero divisor, goes from
// decode straight to the output register. A resistive report first runs the
// gain products through the one shared multiplier and then the two bit-serial
// dividers, which run side by side for x and y. Events are taken one at a time.
// The result sits in an output register, so a new event is accepted while the
// previous report waits; a report finishing while the receiver still stalls is
// held until the register frees up.
// Reset clears the touch state, the pending flag and the result valid, and puts
// every configuration register at its reset value.
module touch_event_assembler_calibrator #(
    parameter int COORD_BITS      = tea_pkg::COORD_BITS_DEF,
    parameter int SCALE_FRAC_BITS = tea_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // event_code[9:0], event_value[41:10], zero fill above
    input  logic [tea_pkg::S_TDATA_W-1:0]  s_tdata,
    // event_type[4:0]
    input  logic [tea_pkg::TYPE_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // raw_x[15:0], raw_y[31:16], pos_x[47:32], pos_y[63:48],
    // contact_size[79:64], contact_changed[80], cal_error[81], zero fill above
    output logic [tea_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tea_pkg::CFG_DATA_W-1:0] cfg_data
);

    tea_pkg::tea_cmd_t    cmd;
    tea_pkg::tea_status_t status;

    assign cfg_ready = 1'b1;

    tea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tea_dp #(
        .COORD_BITS      (COORD_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_type   (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata)
    );

endmodule

[design/tea_checker.sv]
// Port-level checks for the touch event assembler and calibrator, with the bind
// that attaches them to the top level. Depends on tea_pkg.
module tea_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tea_pkg::M_TDATA_W-1:0]  m_tdata
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while the receiver stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while the receiver stalled");

    // Events are worked one at a time, so the input closes right after a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted a second event while one was in flight");

    // A report flagged with a calibration error carries the raw coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[81] |-> (m_tdata[47:32] == m_tdata[15:0])
                                 && (m_tdata[63:48] == m_tdata[31:16]))
        else $error("calibration error report does not pass the raw position");

endmodule

bind touch_event_assembler_calibrator tea_checker u_tea_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
